### design/servo_keyframe_sequencer_unit_defines.svh
// assertion macros used by the servo keyframe sequencer unit
`ifndef SERVO_KEYFRAME_SEQUENCER_UNIT_DEFINES_SVH
`define SERVO_KEYFRAME_SEQUENCER_UNIT_DEFINES_SVH

// implication checked on every clock edge outside reset
`define SKS_ASSERT_IMP(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sks check failed");

// implication whose consequent is checked in the cycle after the antecedent
`define SKS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sks check failed");

`endif

### design/sks_pkg.sv
// ----------------------------------------------------------------------------
// sks_pkg
// shared types and constants of the servo keyframe sequencer
// ----------------------------------------------------------------------------
`default_nettype none
package sks_pkg;
	localparam int NUM_MOTORS = 8;
	localparam int NUM_FRAMES = 16;
	localparam int MW = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;
	localparam int FW = $clog2(NUM_FRAMES + 1);
	localparam int AW = (NUM_FRAMES * NUM_MOTORS > 1) ? $clog2(NUM_FRAMES * NUM_MOTORS) : 1;
	localparam int SLOT_W = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;

	typedef enum logic [2:0] {
		CMD_STAGE  = 3'd0,
		CMD_COMMIT = 3'd1,
		CMD_START  = 3'd2,
		CMD_TICK   = 3'd3,
		CMD_HOME   = 3'd4
	} cmd_t;

	typedef enum logic [1:0] {
		REG_MIN = 2'd0,
		REG_MAX = 2'd1,
		REG_REP = 2'd2
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_COMMIT,
		ST_READ,
		ST_SWEEP,
		ST_FINISH,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] deg;
		logic [15:0] period;
	} kf_entry_t;

	// control broadcast to every cell
	typedef struct packed {
		logic       tick;
		logic       home;
		logic       stage;
		logic       commit;
		logic [2:0] motor;
	} cell_ctl_t;
endpackage
`default_nettype wire

### design/sks_cell.sv
// ----------------------------------------------------------------------------
// sks_cell
// one servo cell: staged entry, position and step time of a single motor
// ----------------------------------------------------------------------------
`default_nettype none
module sks_cell (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                shift,
	input  wire sks_pkg::cell_ctl_t  ctl,
	input  wire logic [2:0]          my_idx,
	input  wire sks_pkg::kf_entry_t  stage_in,
	input  wire sks_pkg::kf_entry_t  frame_in,
	input  wire logic [7:0]          lo,
	input  wire logic [7:0]          hi,
	input  wire logic [31:0]         now_ms,
	input  wire logic                done_in,
	output sks_pkg::kf_entry_t       staged,
	output logic [7:0]               pos,
	output logic                     done_out
);
	import sks_pkg::*;

	kf_entry_t   staged_q;
	logic [7:0]  pos_q;
	logic [31:0] last_q;
	logic [7:0]  target;
	logic        elapsed;
	logic        at_target;

	always_comb begin
		if (frame_in.deg < lo)
			target = lo;
		else if (frame_in.deg > hi)
			target = hi;
		else
			target = frame_in.deg;
		at_target = pos_q == target;
		elapsed = (now_ms - last_q) >= {16'd0, frame_in.period};
	end

	assign done_out = done_in & (!frame_in.valid | at_target);
	assign staged = staged_q;
	assign pos = pos_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			staged_q <= '0;
			pos_q <= '0;
			last_q <= '0;
		end else begin
			if (ctl.stage && ctl.motor == my_idx)
				staged_q <= stage_in;
			else if (ctl.commit)
				staged_q.valid <= 1'b0;
			if (ctl.home)
				pos_q <= lo;
			else if (shift && ctl.tick && frame_in.valid && !at_target) begin
				if (frame_in.period == 16'd0) begin
					pos_q <= target;
				end else if (elapsed) begin
					last_q <= now_ms;
					pos_q <= (target > pos_q) ? pos_q + 8'd1 : pos_q - 8'd1;
				end
			end
		end
	end
endmodule
`default_nettype wire

### design/servo_keyframe_sequencer_unit.sv
// ----------------------------------------------------------------------------
// servo_keyframe_sequencer_unit
// keyframe player driving a row of servo cells
// ----------------------------------------------------------------------------
// s_axis carries one command item; m_axis returns one result item per command.
// Configuration writes go through cfg_we/cfg_index/cfg_data; the user must
// write only while idle, which the block does not enforce. Stage, start,
// home and ignored commands pass the finish and output states to a result.
// Commit copies the staged row into the frame store, one motor a cycle.
// A tick reads the current frame from the store one motor a cycle, each
// entry stepping the matching cell, then sweeps. One item is in work at a
// time. After reset all positions, step times and counters are zero and the
// staged row is empty; the store holds nothing defined. A result waits in the
// output register while m_axis_tready is low and no new item is taken.
// ----------------------------------------------------------------------------
`default_nettype none
`include "servo_keyframe_sequencer_unit_defines.svh"
module servo_keyframe_sequencer_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [63:0] cfg_data,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// cmd[2:0], motor[5:3], degree[13:6], period_ms[29:14], now_ms[61:30], pad
	input  wire logic [63:0] s_axis_tdata,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// positions[63:0], frame_index[68:64], running[69], accepted[70], pad
	output logic [71:0]      m_axis_tdata
);
	import sks_pkg::*;

	logic [63:0] min_q, max_q;
	logic        rep_q;
	state_t      state_q, state_d;
	logic [2:0]  cmd_q;
	logic [2:0]  motor_q;
	logic [7:0]  deg_q;
	logic [15:0] period_q;
	logic [31:0] now_q;
	logic [FW-1:0] loaded_q, cur_q;
	logic        play_q, acc_q;
	logic [MW:0] cnt_q;
	logic [71:0] out_q;
	logic        ov_q;
	kf_entry_t   mem [NUM_FRAMES*NUM_MOTORS];
	kf_entry_t   rd_q;
	logic        rd_v_s1;
	logic [MW-1:0] rd_m_s1;
	logic        done_q;
	cell_ctl_t   ctl;
	kf_entry_t   staged [NUM_MOTORS];
	logic [7:0]  pos [NUM_MOTORS];
	logic        done_c [NUM_MOTORS];
	logic [63:0] packed_pos;
	logic        accept_in;
	logic [SLOT_W-1:0] slot;

	assign accept_in = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = state_q == ST_IDLE && !ov_q;
	assign m_axis_tvalid = ov_q;
	assign m_axis_tdata = out_q;
	assign slot = cur_q[SLOT_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= '0;
			max_q <= 64'hB4B4B4B4B4B4B4B4;
			rep_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MIN: min_q <= cfg_data;
				REG_MAX: max_q <= cfg_data;
				REG_REP: rep_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// cells
	always_comb begin
		ctl = '0;
		ctl.motor = motor_q;
		ctl.tick = 1'b1;
		ctl.stage = state_q == ST_FINISH && cmd_q == CMD_STAGE && acc_q;
		ctl.commit = state_q == ST_FINISH && cmd_q == CMD_COMMIT && acc_q;
		ctl.home = state_q == ST_FINISH && cmd_q == CMD_HOME;
	end

	genvar g;
	generate
		for (g = 0; g < NUM_MOTORS; g++) begin : g_cell
			logic hit;
			assign hit = rd_v_s1 && rd_m_s1 == MW'(g);
			sks_cell u_cell (
				.clk(clk), .arst_n(arst_n),
				.shift(hit), .ctl(ctl), .my_idx(3'(g)),
				.stage_in({1'b1, deg_q, period_q}),
				.frame_in(rd_q),
				.lo(min_q[g*8 +: 8]), .hi(max_q[g*8 +: 8]),
				.now_ms(now_q),
				.done_in(1'b1),
				.staged(staged[g]), .pos(pos[g]), .done_out(done_c[g])
			);
			assign packed_pos[g*8 +: 8] = pos[g];
		end
		for (g = NUM_MOTORS; g < 8; g++) begin : g_pad
			assign packed_pos[g*8 +: 8] = 8'd0;
		end
	endgenerate

	// frame store
	always_ff @(posedge clk) begin
		if (state_q == ST_COMMIT)
			mem[AW'(slot * NUM_MOTORS) + AW'(cnt_q[MW-1:0])] <= staged[cnt_q[MW-1:0]];
		rd_q <= mem[AW'(slot * NUM_MOTORS) + AW'(cnt_q[MW-1:0])];
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (accept_in) begin
				state_d = ST_FINISH;
				if (s_axis_tdata[2:0] == CMD_COMMIT && !play_q && cur_q < FW'(NUM_FRAMES))
					state_d = ST_COMMIT;
				else if (s_axis_tdata[2:0] == CMD_TICK && play_q && loaded_q != '0 &&
						(cur_q < loaded_q || rep_q))
					state_d = ST_READ;
			end
			ST_COMMIT: if (cnt_q == (MW+1)'(NUM_MOTORS - 1)) state_d = ST_FINISH;
			ST_READ:   if (cnt_q == (MW+1)'(NUM_MOTORS - 1)) state_d = ST_SWEEP;
			ST_SWEEP:  state_d = ST_FINISH;
			ST_FINISH: state_d = ST_OUT;
			ST_OUT:    state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cmd_q <= '0; motor_q <= '0; deg_q <= '0; period_q <= '0; now_q <= '0;
			loaded_q <= '0; cur_q <= '0; play_q <= 1'b0; acc_q <= 1'b0;
			cnt_q <= '0; ov_q <= 1'b0; out_q <= '0;
			rd_v_s1 <= 1'b0; rd_m_s1 <= '0; done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			rd_v_s1 <= state_q == ST_READ;
			rd_m_s1 <= cnt_q[MW-1:0];
			if (rd_v_s1)
				done_q <= done_q & done_c[rd_m_s1];
			if (ov_q && m_axis_tready)
				ov_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (accept_in) begin
					cmd_q <= s_axis_tdata[2:0];
					motor_q <= s_axis_tdata[5:3];
					deg_q <= s_axis_tdata[13:6];
					period_q <= s_axis_tdata[29:14];
					now_q <= s_axis_tdata[61:30];
					cnt_q <= '0;
					done_q <= 1'b1;
					acc_q <= 1'b0;
					unique case (s_axis_tdata[2:0])
						CMD_STAGE: acc_q <= !play_q &&
							{1'b0, s_axis_tdata[5:3]} < 4'(NUM_MOTORS);
						CMD_COMMIT: if (!play_q && cur_q < FW'(NUM_FRAMES)) begin
							acc_q <= 1'b1;
						end
						CMD_START: begin
							acc_q <= 1'b1; play_q <= 1'b1;
							loaded_q <= cur_q; cur_q <= '0;
						end
						CMD_TICK: if (play_q && loaded_q != '0) begin
							if (cur_q < loaded_q || rep_q) begin
								acc_q <= 1'b1;
								if (cur_q >= loaded_q)
									cur_q <= '0;
							end
						end
						CMD_HOME: acc_q <= 1'b1;
						default: ;
					endcase
				end
				ST_COMMIT, ST_READ: cnt_q <= cnt_q + 1'b1;
				ST_FINISH: begin
					if (cmd_q == CMD_COMMIT && acc_q)
						cur_q <= cur_q + 1'b1;
					if (cmd_q == CMD_TICK && acc_q && done_q && cur_q < loaded_q)
						cur_q <= cur_q + 1'b1;
				end
				ST_OUT: begin
					out_q <= {1'b0, acc_q, play_q, 5'(cur_q), packed_pos};
					ov_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	`SKS_ASSERT_IMP(a_no_take_busy, state_q != ST_IDLE, !s_axis_tready)
	`SKS_ASSERT_NEXT(a_out_after, state_q == ST_OUT, m_axis_tvalid)
	`SKS_ASSERT_IMP(a_cur_bound, play_q, cur_q <= loaded_q)
endmodule
`default_nettype wire
